### rtl/mwd_pkg.sv
// Shared types and constants for the moving window derivative block.
// No dependencies; used by the front end, execution unit and top level.
`default_nettype none

package mwd_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int WIN_W      = 8;
    localparam int CHREG_W    = 4;
    localparam int ALPHA_W    = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 16'd32768;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd31000;
    localparam logic [WIN_W-1:0]   WIN_RESET   = 8'd16;
    localparam logic [CHREG_W-1:0] CHAN_RESET  = 4'd1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MODE     = 2'd0,
        CFG_WINDOW   = 2'd1,
        CFG_ALPHA    = 2'd2,
        CFG_CHANNELS = 2'd3
    } cfg_addr_t;

    // effective settings seen by the datapath
    typedef struct packed {
        logic               mode;
        logic [WIN_W-1:0]   n;
        logic [ALPHA_W-1:0] alpha;
    } cfg_t;

endpackage

`default_nettype wire

### rtl/mwd_front.sv
// Front end: accepts samples, tracks channel and ring position, classifies
// each sample and pushes it to the work queue. Depends on mwd_pkg.
`default_nettype none

module mwd_front #(
    parameter int SAMPLE_BITS  = 16,
    parameter int MAX_CHANNELS = 8,
    parameter int RING_SLOTS   = 256
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          restart,
    input  wire logic [mwd_pkg::WIN_W-1:0]     n,
    input  wire logic [$clog2(MAX_CHANNELS+1)-1:0] chans,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [SAMPLE_BITS-1:0]        sample,
    input  wire logic                          q_full,
    output logic                               push,
    output logic [SAMPLE_BITS + ((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)
                  + 2 * $clog2(RING_SLOTS * MAX_CHANNELS) + 2:0] item
);

    localparam int S     = SAMPLE_BITS;
    localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int HW    = $clog2(RING_SLOTS);
    localparam int AW    = $clog2(RING_SLOTS * MAX_CHANNELS);
    localparam int MW9   = mwd_pkg::WIN_W + 1;

    typedef struct packed {
        logic [S-1:0]  sample;
        logic [CW-1:0] ch;
        logic [AW-1:0] wr_addr;
        logic [AW-1:0] rd_addr;
        logic          use_ring;
        logic          first;
        logic          last;
    } item_t;

    logic [CW-1:0]  ch_reg;
    logic [HW-1:0]  head_reg;
    logic           first_reg;
    logic           wrapped_reg;

    logic [MW9-1:0] m9;
    logic [MW9-1:0] h_inc9;
    logic [CW-1:0]  ch_cur;
    logic [HW-1:0]  h_cur;
    logic [HW-1:0]  rd_slot;
    logic           wrap;
    logic           last;
    logic           accept;
    item_t          it;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept;

    always_comb begin
        m9      = MW9'(n) + MW9'(1);
        ch_cur  = (CNT_W'(ch_reg) >= chans) ? '0 : ch_reg;
        h_cur   = (MW9'(head_reg) >= m9) ? '0 : head_reg;
        h_inc9  = MW9'(h_cur) + MW9'(1);
        wrap    = (h_inc9 == m9);
        rd_slot = wrap ? '0 : HW'(h_inc9);
        last    = ((CNT_W'(ch_cur) + CNT_W'(1)) == chans);
        it.sample   = sample;
        it.ch       = ch_cur;
        it.wr_addr  = AW'(32'(h_cur) * MAX_CHANNELS + 32'(ch_cur));
        it.rd_addr  = AW'(32'(rd_slot) * MAX_CHANNELS + 32'(ch_cur));
        it.use_ring = wrapped_reg || (rd_slot <= h_cur);
        it.first    = first_reg;
        it.last     = last;
    end

    assign item = it;

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            ch_reg      <= '0;
            head_reg    <= '0;
            first_reg   <= 1'b1;
            wrapped_reg <= 1'b0;
        end else if (accept) begin
            if (last) begin
                ch_reg    <= '0;
                first_reg <= 1'b0;
                if (wrap) begin
                    head_reg    <= '0;
                    wrapped_reg <= 1'b1;
                end else begin
                    head_reg <= HW'(h_inc9);
                end
            end else begin
                ch_reg   <= ch_cur + CW'(1);
                head_reg <= h_cur;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/mwd_queue.sv
// Two-entry queue between the front end and the execution unit.
// No dependencies.
`default_nettype none

module mwd_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    output logic                  valid,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      dout
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wp_reg;
    logic             rp_reg;
    logic [1:0]       cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign dout  = slot_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= !wp_reg;
            end
            if (pop) begin
                rp_reg <= !rp_reg;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/mwd_back.sv
// Execution unit: history ring, per-channel sums and averages, serial divider
// and the output register. Depends on mwd_pkg.
`default_nettype none

module mwd_back #(
    parameter int SAMPLE_BITS  = 16,
    parameter int MAX_CHANNELS = 8,
    parameter int RING_SLOTS   = 256
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire mwd_pkg::cfg_t cfg,
    input  wire logic          item_valid,
    input  wire logic [SAMPLE_BITS + ((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)
                       + 2 * $clog2(RING_SLOTS * MAX_CHANNELS) + 2:0] item,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [SAMPLE_BITS:0] out_deriv,
    output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] out_ch,
    output logic               out_last
);

    localparam int S     = SAMPLE_BITS;
    localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int AW    = $clog2(RING_SLOTS * MAX_CHANNELS);
    localparam int DEPTH = RING_SLOTS * MAX_CHANNELS;
    localparam int SUM_W = S + 8;
    localparam int MW    = S + 9;
    localparam int DCW   = $clog2(MW + 1);

    typedef struct packed {
        logic [S-1:0]  sample;
        logic [CW-1:0] ch;
        logic [AW-1:0] wr_addr;
        logic [AW-1:0] rd_addr;
        logic          use_ring;
        logic          first;
        logic          last;
    } item_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_READ = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_PREP = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    item_t  item_reg;

    logic signed [S-1:0]     ring_mem [DEPTH];
    logic signed [S-1:0]     ring_q_reg;
    logic signed [S-1:0]     first_mem [MAX_CHANNELS];
    logic signed [SUM_W-1:0] sum_mem   [MAX_CHANNELS];
    logic signed [S-1:0]     avg_mem   [MAX_CHANNELS];

    logic signed [S-1:0]   old_reg;
    logic signed [S+9:0]   pmv_reg;
    logic signed [S+16:0]  pa_reg;
    logic signed [S+16:0]  pb_reg;
    logic signed [S:0]     sl_reg;
    logic [MW-1:0]         mag_reg;
    logic [MW-1:0]         quo_reg;
    logic [9:0]            rem_reg;
    logic                  neg_reg;
    logic [DCW-1:0]        cnt_reg;

    logic signed [S-1:0]     x;
    logic signed [S-1:0]     old_sel;
    logic signed [S:0]       pair;
    logic signed [S+9:0]     numer;
    logic signed [S+17:0]    tot;
    logic signed [SUM_W-1:0] sum_new;
    logic [mwd_pkg::ALPHA_W-1:0] om;
    logic [9:0]              rem_s;
    logic [9:0]              dv;
    logic                    q_bit;
    logic [MW-1:0]           mv_full;
    logic                    out_free;

    assign x        = item_reg.sample;
    assign om       = mwd_pkg::ALPHA_ONE - cfg.alpha;
    assign dv       = {1'b0, cfg.n, 1'b0};
    assign out_free = !out_valid || out_ready;

    always_comb begin
        old_sel = item_reg.use_ring ? ring_q_reg : first_mem[item_reg.ch];
        pair    = {old_sel[S-1], old_sel} + {x[S-1], x};
        numer   = pmv_reg - $signed({sum_mem[item_reg.ch], 1'b0});
        sum_new = sum_mem[item_reg.ch] - SUM_W'(old_reg) + SUM_W'(x);
        tot     = (S+18)'(pa_reg) + (S+18)'(pb_reg);
        rem_s   = {rem_reg[8:0], mag_reg[MW-1]};
        q_bit   = (rem_s >= dv);
        mv_full = neg_reg ? (~quo_reg + MW'(1)) : quo_reg;
    end

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    pop        = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_PREP;
            ST_PREP: state_next = ST_DIV;
            ST_DIV: begin
                if (cnt_reg == DCW'(MW - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) begin
                out_valid <= 1'b1;
            end else if (out_ready) begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            ring_mem[item_reg.wr_addr] <= x;
            ring_q_reg <= ring_mem[item_reg.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    item_reg <= item;
                end
            end
            ST_READ: begin
                if (item_reg.first) begin
                    first_mem[item_reg.ch] <= x;
                    avg_mem[item_reg.ch]   <= x;
                    sum_mem[item_reg.ch]   <= SUM_W'($signed({1'b0, cfg.n}) * SUM_W'(x));
                end
            end
            ST_MUL: begin
                old_reg <= old_sel;
                pmv_reg <= $signed({1'b0, cfg.n}) * pair;
                pa_reg  <= $signed({1'b0, cfg.alpha}) * avg_mem[item_reg.ch];
                pb_reg  <= $signed({1'b0, om}) * x;
            end
            ST_PREP: begin
                sum_mem[item_reg.ch] <= sum_new;
                avg_mem[item_reg.ch] <= tot[S+14:15];
                sl_reg  <= {x[S-1], x} - {avg_mem[item_reg.ch][S-1], avg_mem[item_reg.ch]};
                neg_reg <= numer[S+9];
                mag_reg <= numer[S+9] ? MW'(-numer) : MW'(numer);
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            ST_DIV: begin
                rem_reg <= q_bit ? (rem_s - dv) : rem_s;
                quo_reg <= {quo_reg[MW-2:0], q_bit};
                mag_reg <= {mag_reg[MW-2:0], 1'b0};
                cnt_reg <= cnt_reg + DCW'(1);
            end
            ST_OUT: begin
                if (out_free) begin
                    out_deriv <= cfg.mode ? sl_reg : mv_full[S:0];
                    out_ch    <= item_reg.ch;
                    out_last  <= item_reg.last;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### rtl/moving_window_derivative.sv
// Top level of the moving window derivative block: configuration registers, front end,
// work queue and execution unit. Depends on mwd_pkg, mwd_front, mwd_queue and mwd_back.
//
// Usage:
//   s_ channel carries one signed sample per beat, channels interleaved 0..C-1.
//   m_ channel returns one beat per sample: derivative in m_tdata, its channel
//   in m_tuser, m_tlast on the last channel of each frame.
//   cfg_wen/cfg_addr/cfg_wdata write mode, window, alpha, channels; write only
//   while idle. Writing window or channels restarts the frame and ring tracking.
// Sequencing:
//   Each sample passes the read, multiply, prepare, divide and output states in
//   turn; the divider is bit-serial for the window mean, and the unit takes no new
//   sample until it is back in idle. A two-entry queue lets the input run ahead.
// Reset (aresetn low, synchronous): registers take their defaults, the stream
//   restarts, m_tvalid drops. The history ring is not cleared.
// Stall: a held m_tready keeps the result in the output register; the unit
//   waits, the queue fills and s_tready drops.
`default_nettype none

module moving_window_derivative #(
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_WINDOW   = 255,
    parameter int SAMPLE_BITS  = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // sample
    output logic      m_tvalid,
    input  wire logic m_tready,
    output logic [((SAMPLE_BITS + 8) / 8) * 8 - 1:0] m_tdata,       // derivative
    output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] m_tuser, // channel
    output logic      m_tlast,
    input  wire logic cfg_wen,
    input  wire logic [mwd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [mwd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int S          = SAMPLE_BITS;
    localparam int CW         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W      = $clog2(MAX_CHANNELS + 1);
    localparam int NMAX       = (MAX_WINDOW < 255) ? MAX_WINDOW : 255;
    localparam int RING_SLOTS = NMAX + 1;
    localparam int AW         = $clog2(RING_SLOTS * MAX_CHANNELS);
    localparam int ITEM_W     = S + CW + 2 * AW + 3;
    localparam int M_TW       = ((S + 8) / 8) * 8;

    logic                          mode_reg;
    logic [mwd_pkg::WIN_W-1:0]     win_reg;
    logic [mwd_pkg::ALPHA_W-1:0]   alpha_reg;
    logic [mwd_pkg::CHREG_W-1:0]   chan_reg;

    mwd_pkg::cfg_t  cfg;
    logic [CNT_W-1:0] chans;
    logic           restart;
    logic           push;
    logic           q_full;
    logic           q_valid;
    logic           pop;
    logic [ITEM_W-1:0] item_in;
    logic [ITEM_W-1:0] item_out;
    logic [S:0]     deriv;

    assign restart = cfg_wen && (cfg_addr == mwd_pkg::CFG_WINDOW ||
                                 cfg_addr == mwd_pkg::CFG_CHANNELS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            win_reg   <= mwd_pkg::WIN_RESET;
            alpha_reg <= mwd_pkg::ALPHA_RESET;
            chan_reg  <= mwd_pkg::CHAN_RESET;
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                mwd_pkg::CFG_MODE:     mode_reg  <= cfg_wdata[0];
                mwd_pkg::CFG_WINDOW:   win_reg   <= cfg_wdata[mwd_pkg::WIN_W-1:0];
                mwd_pkg::CFG_ALPHA:    alpha_reg <= cfg_wdata;
                mwd_pkg::CFG_CHANNELS: chan_reg  <= cfg_wdata[mwd_pkg::CHREG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.mode = mode_reg;
        if (win_reg == '0) begin
            cfg.n = 8'd1;
        end else if (32'(win_reg) > NMAX) begin
            cfg.n = 8'(NMAX);
        end else begin
            cfg.n = win_reg;
        end
        cfg.alpha = (alpha_reg > mwd_pkg::ALPHA_ONE) ? mwd_pkg::ALPHA_ONE : alpha_reg;
        if (chan_reg == '0) begin
            chans = CNT_W'(1);
        end else if (32'(chan_reg) > MAX_CHANNELS) begin
            chans = CNT_W'(MAX_CHANNELS);
        end else begin
            chans = CNT_W'(chan_reg);
        end
    end

    mwd_front #(
        .SAMPLE_BITS (S),
        .MAX_CHANNELS(MAX_CHANNELS),
        .RING_SLOTS  (RING_SLOTS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (restart),
        .n       (cfg.n),
        .chans   (chans),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sample  (s_tdata[S-1:0]),
        .q_full  (q_full),
        .push    (push),
        .item    (item_in)
    );

    mwd_queue #(
        .WIDTH(ITEM_W)
    ) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push),
        .din    (item_in),
        .full   (q_full),
        .valid  (q_valid),
        .pop    (pop),
        .dout   (item_out)
    );

    mwd_back #(
        .SAMPLE_BITS (S),
        .MAX_CHANNELS(MAX_CHANNELS),
        .RING_SLOTS  (RING_SLOTS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .item_valid(q_valid),
        .item      (item_out),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_deriv (deriv),
        .out_ch    (m_tuser),
        .out_last  (m_tlast)
    );

    assign m_tdata = M_TW'(deriv);

endmodule

`default_nettype wire

### rtl/mwd_checker.sv
// Port-level checks on the moving window derivative result channel, bound
// to the top level. Depends on moving_window_derivative.
`default_nettype none

module mwd_checker #(
    parameter int MAX_CHANNELS = 8,
    parameter int TD_W         = 24,
    parameter int TU_W         = 3
) (
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            m_tvalid,
    input wire logic            m_tready,
    input wire logic [TD_W-1:0] m_tdata,
    input wire logic [TU_W-1:0] m_tuser,
    input wire logic            m_tlast
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    a_top_channel_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == TU_W'(MAX_CHANNELS - 1)) |-> m_tlast)
        else $error("highest channel without frame end");

endmodule

bind moving_window_derivative mwd_checker #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .TD_W        (((SAMPLE_BITS + 8) / 8) * 8),
    .TU_W        ((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)
) u_mwd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);

`default_nettype wire
